// File: src/upp_pkg.sv
`timescale 1ns / 1ps
package upp_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int POS_BITS_DEF   = 32;

    localparam int PHASE_BITS   = 32;
    localparam int CORDIC_ITERS = 20;
    localparam int CORDIC_W     = 33;
    localparam int TRIG_W       = 16;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;
    localparam logic signed [TRIG_W-1:0]   TRIG_ONE        = 16'sd16384;

    localparam logic [1:0] REG_NOISE_X       = 2'd0;
    localparam logic [1:0] REG_NOISE_Y       = 2'd1;
    localparam logic [1:0] REG_NOISE_HEADING = 2'd2;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic [1:0]                 quad;
    } cordic_res_t;

    function automatic logic signed [PHASE_BITS-1:0] atan_turn(input int unsigned idx);
        logic signed [PHASE_BITS-1:0] a;
        case (idx)
            0:       a = 32'sd536870912;
            1:       a = 32'sd316933406;
            2:       a = 32'sd167458907;
            3:       a = 32'sd85004756;
            4:       a = 32'sd42667331;
            5:       a = 32'sd21354465;
            6:       a = 32'sd10679838;
            7:       a = 32'sd5340245;
            8:       a = 32'sd2670163;
            9:       a = 32'sd1335087;
            10:      a = 32'sd667544;
            11:      a = 32'sd333772;
            12:      a = 32'sd166886;
            13:      a = 32'sd83443;
            14:      a = 32'sd41722;
            15:      a = 32'sd20861;
            16:      a = 32'sd10430;
            17:      a = 32'sd5215;
            18:      a = 32'sd2608;
            19:      a = 32'sd1304;
            default: a = '0;
        endcase
        return a;
    endfunction

    // round half up to Q2.14 and clamp to one
    function automatic logic signed [TRIG_W-1:0] to_q14(input logic signed [CORDIC_W-1:0] v);
        logic [CORDIC_W:0]           t;
        logic signed [CORDIC_W-16:0] r;
        t = {v[CORDIC_W-1], v} + (CORDIC_W+1)'(32768);
        r = $signed(t[CORDIC_W:16]);
        if (r > TRIG_ONE) begin
            return TRIG_ONE;
        end else if (r < -TRIG_ONE) begin
            return -TRIG_ONE;
        end
        return r[TRIG_W-1:0];
    endfunction

endpackage

// File: src/unicycle_pose_predict_unit.sv
`timescale 1ns / 1ps
// Unicycle pose prediction with motion Jacobian.
// Input channel (s_valid/s_ready): pose x, y, heading plus a distance step and
// a heading change. Result channel (m_valid/m_ready): predicted pose, the two
// entries of the Jacobian's heading column and a saturation flag.
// Noise means are set over the APB port at 0x0 (x), 0x4 (y), 0x8 (heading);
// write them only while no transfer is in flight.
// Throughput: one transfer per cycle while s_ready is high. Pipeline: 24 register
// stages, made up of the 20-stage CORDIC, three arithmetic stages (trig rounding,
// multiply, sum) and the output register.
// Reset: synchronous, active low; clears all stage valid bits, the output
// buffer and the noise means. No clearing pass follows.
// Receiver stall: the output register holds its result, one skid entry takes
// the next result, then s_ready drops and the whole pipeline holds in place.
module unicycle_pose_predict_unit import upp_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int POS_BITS   = POS_BITS_DEF,
    localparam int PDATA_W   = (POS_BITS > 32) ? 64 : 32,
    localparam int ADDR_LSB  = (POS_BITS > 32) ? 3 : 2,
    localparam int ADDR_W    = ADDR_LSB + 2
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [POS_BITS-1:0] s_pose_x,
    input  logic signed [POS_BITS-1:0] s_pose_y,
    input  logic [ANGLE_BITS-1:0]      s_pose_heading,
    input  logic signed [POS_BITS-1:0] s_speed_step,
    input  logic signed [ANGLE_BITS-1:0] s_turn_step,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [POS_BITS-1:0] m_next_x,
    output logic signed [POS_BITS-1:0] m_next_y,
    output logic [ANGLE_BITS-1:0]      m_next_heading,
    output logic signed [POS_BITS-1:0] m_dx_dheading,
    output logic signed [POS_BITS-1:0] m_dy_dheading,
    output logic                       m_overflow
);

    localparam int SIDE_W = 3 * POS_BITS + ANGLE_BITS;
    localparam int OUT_W  = 4 * POS_BITS + ANGLE_BITS + 1;

    logic signed [POS_BITS-1:0]   noise_x_reg, noise_y_reg;
    logic signed [ANGLE_BITS-1:0] noise_h_reg;
    logic [1:0]                   reg_idx;
    logic                         wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_LSB+1:ADDR_LSB];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            noise_x_reg <= '0;
            noise_y_reg <= '0;
            noise_h_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_NOISE_X:       noise_x_reg <= pwdata[POS_BITS-1:0];
                REG_NOISE_Y:       noise_y_reg <= pwdata[POS_BITS-1:0];
                REG_NOISE_HEADING: noise_h_reg <= pwdata[ANGLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_NOISE_X:       prdata = PDATA_W'(noise_x_reg);
            REG_NOISE_Y:       prdata = PDATA_W'(noise_y_reg);
            REG_NOISE_HEADING: prdata = PDATA_W'(noise_h_reg);
            default:           prdata = '0;
        endcase
    end

    logic                  en;
    logic [ANGLE_BITS-1:0] head_sum;
    logic [PHASE_BITS-1:0] phase;
    logic [SIDE_W-1:0]     side_in, side_out;

    assign s_ready  = en;
    assign head_sum = s_pose_heading + $unsigned(s_turn_step) + $unsigned(noise_h_reg);
    assign phase    = PHASE_BITS'(s_pose_heading) << (PHASE_BITS - ANGLE_BITS);
    assign side_in  = {s_pose_x, s_pose_y, s_speed_step, head_sum};

    logic        cor_valid;
    cordic_res_t cor_res;

    upp_cordic #(
        .SIDE_W (SIDE_W)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_phase  (phase),
        .in_side   (side_in),
        .out_valid (cor_valid),
        .out_res   (cor_res),
        .out_side  (side_out)
    );

    logic                       post_valid;
    logic signed [POS_BITS-1:0] nx, ny, jx, jy;
    logic [ANGLE_BITS-1:0]      nh;
    logic                       ovf;

    upp_post #(
        .POS_BITS   (POS_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_post (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (cor_valid),
        .in_res       (cor_res),
        .in_px        ($signed(side_out[SIDE_W-1 -: POS_BITS])),
        .in_py        ($signed(side_out[SIDE_W-POS_BITS-1 -: POS_BITS])),
        .in_v         ($signed(side_out[SIDE_W-2*POS_BITS-1 -: POS_BITS])),
        .in_heading   (side_out[ANGLE_BITS-1:0]),
        .noise_x      (noise_x_reg),
        .noise_y      (noise_y_reg),
        .out_valid    (post_valid),
        .next_x       (nx),
        .next_y       (ny),
        .next_heading (nh),
        .dx_dheading  (jx),
        .dy_dheading  (jy),
        .overflow     (ovf)
    );

    logic [OUT_W-1:0] buf_in, buf_out;

    assign buf_in = {nx, ny, nh, jx, jy, ovf};

    upp_out_buf #(
        .DATA_W (OUT_W)
    ) u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (post_valid),
        .in_data   (buf_in),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (buf_out)
    );

    assign m_next_x       = $signed(buf_out[OUT_W-1 -: POS_BITS]);
    assign m_next_y       = $signed(buf_out[OUT_W-POS_BITS-1 -: POS_BITS]);
    assign m_next_heading = buf_out[OUT_W-2*POS_BITS-1 -: ANGLE_BITS];
    assign m_dx_dheading  = $signed(buf_out[2*POS_BITS:POS_BITS+1]);
    assign m_dy_dheading  = $signed(buf_out[POS_BITS:1]);
    assign m_overflow     = buf_out[0];

endmodule

// File: src/upp_cordic.sv
`timescale 1ns / 1ps
module upp_cordic import upp_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [PHASE_BITS-1:0] in_phase,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output cordic_res_t           out_res,
    output logic [SIDE_W-1:0]     out_side
);

    logic [CORDIC_ITERS-1:0]      valid_reg;
    logic signed [CORDIC_W-1:0]   x_reg    [CORDIC_ITERS];
    logic signed [CORDIC_W-1:0]   y_reg    [CORDIC_ITERS];
    logic signed [PHASE_BITS-1:0] z_reg    [CORDIC_ITERS];
    logic [1:0]                   quad_reg [CORDIC_ITERS];
    logic [SIDE_W-1:0]            side_reg [CORDIC_ITERS];

    for (genvar k = 0; k < CORDIC_ITERS; k++) begin : stage_g
        logic                         v_in;
        logic signed [CORDIC_W-1:0]   x_in;
        logic signed [CORDIC_W-1:0]   y_in;
        logic signed [PHASE_BITS-1:0] z_in;
        logic [1:0]                   quad_in;
        logic [SIDE_W-1:0]            side_in;
        logic signed [CORDIC_W-1:0]   x_next;
        logic signed [CORDIC_W-1:0]   y_next;
        logic signed [PHASE_BITS-1:0] z_next;

        if (k == 0) begin : first_g
            assign v_in    = in_valid;
            assign x_in    = CORDIC_GAIN_Q30;
            assign y_in    = '0;
            assign z_in    = $signed({2'b00, in_phase[PHASE_BITS-3:0]});
            assign quad_in = in_phase[PHASE_BITS-1:PHASE_BITS-2];
            assign side_in = in_side;
        end else begin : chain_g
            assign v_in    = valid_reg[k-1];
            assign x_in    = x_reg[k-1];
            assign y_in    = y_reg[k-1];
            assign z_in    = z_reg[k-1];
            assign quad_in = quad_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb begin
            if (z_in >= 0) begin
                x_next = x_in - (y_in >>> k);
                y_next = y_in + (x_in >>> k);
                z_next = z_in - atan_turn(k);
            end else begin
                x_next = x_in + (y_in >>> k);
                y_next = y_in - (x_in >>> k);
                z_next = z_in + atan_turn(k);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[k]    <= x_next;
                y_reg[k]    <= y_next;
                z_reg[k]    <= z_next;
                quad_reg[k] <= quad_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid    = valid_reg[CORDIC_ITERS-1];
    assign out_res.x    = x_reg[CORDIC_ITERS-1];
    assign out_res.y    = y_reg[CORDIC_ITERS-1];
    assign out_res.quad = quad_reg[CORDIC_ITERS-1];
    assign out_side     = side_reg[CORDIC_ITERS-1];

endmodule

// File: src/upp_post.sv
`timescale 1ns / 1ps
module upp_post import upp_pkg::*; #(
    parameter int POS_BITS   = POS_BITS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  cordic_res_t                 in_res,
    input  logic signed [POS_BITS-1:0]  in_px,
    input  logic signed [POS_BITS-1:0]  in_py,
    input  logic signed [POS_BITS-1:0]  in_v,
    input  logic [ANGLE_BITS-1:0]       in_heading,
    input  logic signed [POS_BITS-1:0]  noise_x,
    input  logic signed [POS_BITS-1:0]  noise_y,
    output logic                        out_valid,
    output logic signed [POS_BITS-1:0]  next_x,
    output logic signed [POS_BITS-1:0]  next_y,
    output logic [ANGLE_BITS-1:0]       next_heading,
    output logic signed [POS_BITS-1:0]  dx_dheading,
    output logic signed [POS_BITS-1:0]  dy_dheading,
    output logic                        overflow
);

    localparam int PROD_W = POS_BITS + TRIG_W;
    localparam int VC_W   = PROD_W - 14;
    localparam int SUM_W  = POS_BITS + 3;

    localparam logic signed [SUM_W-1:0] POS_MAX =
        {{(SUM_W-POS_BITS+1){1'b0}}, {(POS_BITS-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] POS_MIN =
        {{(SUM_W-POS_BITS+1){1'b1}}, {(POS_BITS-1){1'b0}}};

    function automatic logic is_sat(input logic signed [SUM_W-1:0] v);
        return (v > POS_MAX) || (v < POS_MIN);
    endfunction

    function automatic logic signed [POS_BITS-1:0] sat_val(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        if (v > POS_MAX) begin
            r = POS_MAX;
        end else if (v < POS_MIN) begin
            r = POS_MIN;
        end else begin
            r = v;
        end
        return r[POS_BITS-1:0];
    endfunction

    logic signed [CORDIC_W-1:0] c_raw;
    logic signed [CORDIC_W-1:0] s_raw;

    always_comb begin
        unique case (in_res.quad)
            2'd0: begin c_raw = in_res.x;  s_raw = in_res.y;  end
            2'd1: begin c_raw = -in_res.y; s_raw = in_res.x;  end
            2'd2: begin c_raw = -in_res.x; s_raw = -in_res.y; end
            2'd3: begin c_raw = in_res.y;  s_raw = -in_res.x; end
        endcase
    end

    logic                       valid1_reg, valid2_reg, valid3_reg;
    logic signed [TRIG_W-1:0]   c_reg, s_reg;
    logic signed [POS_BITS-1:0] px1_reg, py1_reg, v1_reg, px2_reg, py2_reg;
    logic [ANGLE_BITS-1:0]      h1_reg, h2_reg, h3_reg;
    logic signed [PROD_W-1:0]   vc_prod_reg, vs_prod_reg;
    logic signed [SUM_W-1:0]    sum_x_reg, sum_y_reg, jx_reg, jy_reg;

    logic [PROD_W-1:0]          vc_rnd, vs_rnd;
    logic signed [VC_W-1:0]     vc, vs;
    logic signed [SUM_W-1:0]    sum_x_next, sum_y_next, jx_next, jy_next;

    always_comb begin
        vc_rnd     = vc_prod_reg + PROD_W'(8192);
        vs_rnd     = vs_prod_reg + PROD_W'(8192);
        vc         = $signed(vc_rnd[PROD_W-1:14]);
        vs         = $signed(vs_rnd[PROD_W-1:14]);
        sum_x_next = SUM_W'(px2_reg) + SUM_W'(vc) + SUM_W'(noise_x);
        sum_y_next = SUM_W'(py2_reg) + SUM_W'(vs) + SUM_W'(noise_y);
        jx_next    = -SUM_W'(vs);
        jy_next    = SUM_W'(vc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end else if (en) begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg       <= to_q14(c_raw);
            s_reg       <= to_q14(s_raw);
            px1_reg     <= in_px;
            py1_reg     <= in_py;
            v1_reg      <= in_v;
            h1_reg      <= in_heading;
            vc_prod_reg <= PROD_W'(v1_reg) * PROD_W'(c_reg);
            vs_prod_reg <= PROD_W'(v1_reg) * PROD_W'(s_reg);
            px2_reg     <= px1_reg;
            py2_reg     <= py1_reg;
            h2_reg      <= h1_reg;
            sum_x_reg   <= sum_x_next;
            sum_y_reg   <= sum_y_next;
            jx_reg      <= jx_next;
            jy_reg      <= jy_next;
            h3_reg      <= h2_reg;
        end
    end

    assign out_valid    = valid3_reg;
    assign next_x       = sat_val(sum_x_reg);
    assign next_y       = sat_val(sum_y_reg);
    assign next_heading = h3_reg;
    assign dx_dheading  = sat_val(jx_reg);
    assign dy_dheading  = sat_val(jy_reg);
    assign overflow     = is_sat(sum_x_reg) || is_sat(sum_y_reg);

endmodule

// File: src/upp_out_buf.sv
`timescale 1ns / 1ps
module upp_out_buf #(
    parameter int DATA_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    output logic              en,
    input  logic              in_valid,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    logic              main_valid_reg, skid_valid_reg;
    logic [DATA_W-1:0] main_data_reg, skid_data_reg;

    assign en = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_ready) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (!main_valid_reg || out_ready) begin
            main_valid_reg <= in_valid;
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_ready) begin
                main_data_reg <= skid_data_reg;
            end
        end else if (!main_valid_reg || out_ready) begin
            main_data_reg <= in_data;
        end else begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

endmodule

// File: src/upp_checker.sv
`timescale 1ns / 1ps
module upp_checker import upp_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int POS_BITS   = POS_BITS_DEF
) (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic signed [POS_BITS-1:0] m_next_x,
    input logic signed [POS_BITS-1:0] m_next_y,
    input logic [ANGLE_BITS-1:0]      m_next_heading,
    input logic signed [POS_BITS-1:0] m_dx_dheading,
    input logic signed [POS_BITS-1:0] m_dy_dheading,
    input logic                       m_overflow
);

    localparam logic signed [POS_BITS-1:0] P_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
    localparam logic signed [POS_BITS-1:0] P_MIN = {1'b1, {(POS_BITS-1){1'b0}}};

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_next_x) && $stable(m_next_y)
            && $stable(m_next_heading) && $stable(m_dx_dheading)
            && $stable(m_dy_dheading) && $stable(m_overflow))
        else $error("result changed under stall");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_ovf_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> (m_next_x == P_MAX) || (m_next_x == P_MIN)
            || (m_next_y == P_MAX) || (m_next_y == P_MIN))
        else $error("overflow flag without a saturated position");

    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> $past(m_valid && !m_ready))
        else $error("input stalled without an output stall");

endmodule

bind unicycle_pose_predict_unit upp_checker #(
    .ANGLE_BITS (ANGLE_BITS),
    .POS_BITS   (POS_BITS)
) u_upp_checker (.*);
